// ----- hdl/okvl_pkg.sv -----
// okvl_pkg: shared constants, request codes and controller/datapath
// command and status types for the ordered key/value list
// depends on nothing
package okvl_pkg;

  // default list capacity
  localparam int DEF_CAPACITY = 16;

  // field widths fixed by the interface
  localparam int KIND_W = 3;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  // operations carried out at the accept edge
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_REJECT = 3'd4
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic load_search;
    logic load_shift;
    logic search_step;
    logic search_end;
    logic shift_step;
    logic shift_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic pos_in_range;
  } status_t;

endpackage

// ----- hdl/okvl_ctrl.sv -----
// okvl_ctrl: request decoder and sequencer for search and remove-at walks
// depends on okvl_pkg (command/status types, request codes)
module okvl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [okvl_pkg::KIND_W-1:0] in_kind,
  input  okvl_pkg::status_t           status,
  output okvl_pkg::cmd_t              cmd,
  output logic                        busy
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_SHIFT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    cmd.op    = okvl_pkg::OP_NONE;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            okvl_pkg::KIND_SEARCH: begin
              cmd.load_search = 1'b1;
              state_nxt       = ST_SEARCH;
            end
            okvl_pkg::KIND_APPEND: cmd.op = okvl_pkg::OP_APPEND;
            okvl_pkg::KIND_POP:    cmd.op = okvl_pkg::OP_POP;
            okvl_pkg::KIND_REMOVE_AT: begin
              if (status.pos_in_range) begin
                cmd.load_shift = 1'b1;
                state_nxt      = ST_SHIFT;
              end else begin
                cmd.op = okvl_pkg::OP_REJECT;
              end
            end
            okvl_pkg::KIND_CLEAR:  cmd.op = okvl_pkg::OP_CLEAR;
            default:               cmd.op = okvl_pkg::OP_REJECT;
          endcase
        end
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          cmd.search_end = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          cmd.shift_end = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hdl/okvl_dpath.sv -----
// okvl_dpath: entry memory, fill count, walk pointers and result registers
// depends on okvl_pkg (widths, command/status types)
module okvl_dpath #(
  parameter int CAPACITY = okvl_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  okvl_pkg::cmd_t                    cmd,
  output okvl_pkg::status_t                 status,
  input  logic signed [okvl_pkg::KEY_W-1:0] in_key,
  input  logic signed [okvl_pkg::VAL_W-1:0] in_value,
  input  logic [okvl_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [okvl_pkg::KEY_W-1:0] out_found_key,
  output logic signed [okvl_pkg::VAL_W-1:0] out_found_value,
  output logic                              out_is_empty
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > okvl_pkg::POS_W) ? CW : okvl_pkg::POS_W;
  localparam int DW   = okvl_pkg::KEY_W + okvl_pkg::VAL_W;

  // entry store, key in the upper half
  logic [DW-1:0] entry_mem_r [CAPACITY];
  logic [DW-1:0] rd_data_r;

  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]              wr_idx_r;
  logic                       pend_r, pend_nxt;
  logic [okvl_pkg::KEY_W-1:0] key_r;

  logic          full, rd_more, hit;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          reply, ok_nxt;

  logic                              out_valid_r;
  logic                              out_ok_r;
  logic signed [okvl_pkg::KEY_W-1:0] out_found_key_r;
  logic signed [okvl_pkg::VAL_W-1:0] out_found_value_r;
  logic                              out_is_empty_r;

  // status toward the controller
  assign full    = (count_r == CW'(CAPACITY));
  assign rd_more = (rd_idx_r < count_r);
  assign hit     = pend_r && (rd_data_r[DW-1 -: okvl_pkg::KEY_W] == key_r);

  assign status.search_done  = hit || (rd_idx_r == count_r);
  assign status.shift_done   = !pend_r && (rd_idx_r == count_r);
  assign status.pos_in_range = (CMPW'(in_position) < CMPW'(count_r));

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = {in_key, in_value};
    if (cmd.op == okvl_pkg::OP_APPEND && !full) begin
      mem_we = 1'b1;
    end else if (cmd.shift_step && pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_idx_r;
      mem_wdata = rd_data_r;
    end
  end

  assign mem_re = (cmd.search_step || cmd.shift_step) && rd_more;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= entry_mem_r[rd_idx_r[AW-1:0]];
    end
  end

  // walk pointers and fill count
  always_comb begin
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = pend_r;
    if (cmd.load_search) begin
      rd_idx_nxt = '0;
      pend_nxt   = 1'b0;
    end
    if (cmd.load_shift) begin
      rd_idx_nxt = CW'(in_position) + CW'(1);
      pend_nxt   = 1'b0;
    end
    if (cmd.search_step || cmd.shift_step) begin
      pend_nxt = rd_more;
      if (rd_more) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
    end
    case (cmd.op)
      okvl_pkg::OP_APPEND: if (!full) count_nxt = count_r + CW'(1);
      okvl_pkg::OP_POP:    if (count_r != '0) count_nxt = count_r - CW'(1);
      okvl_pkg::OP_CLEAR:  count_nxt = '0;
      default:             count_nxt = count_r;
    endcase
    if (cmd.shift_end) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // result of the finishing request
  always_comb begin
    reply = (cmd.op != okvl_pkg::OP_NONE) || cmd.search_end || cmd.shift_end;
    case (cmd.op)
      okvl_pkg::OP_APPEND: ok_nxt = !full;
      okvl_pkg::OP_POP:    ok_nxt = (count_r != '0);
      okvl_pkg::OP_CLEAR:  ok_nxt = 1'b1;
      default:             ok_nxt = 1'b0;
    endcase
    if (cmd.search_end) begin
      ok_nxt = hit;
    end
    if (cmd.shift_end) begin
      ok_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= reply;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (cmd.load_search) begin
      key_r <= in_key;
    end
    if (mem_re) begin
      wr_idx_r <= AW'(rd_idx_r - CW'(1));
    end
    if (reply) begin
      out_ok_r       <= ok_nxt;
      out_is_empty_r <= (count_nxt == '0);
      if (cmd.search_end && hit) begin
        out_found_key_r   <= rd_data_r[DW-1 -: okvl_pkg::KEY_W];
        out_found_value_r <= rd_data_r[okvl_pkg::VAL_W-1:0];
      end else begin
        out_found_key_r   <= '0;
        out_found_value_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_key   = out_found_key_r;
  assign out_found_value = out_found_value_r;
  assign out_is_empty    = out_is_empty_r;

endmodule

// ----- hdl/ordered_key_value_list.sv -----
// ordered_key_value_list: top level joining the sequencer and the datapath
// depends on okvl_pkg, okvl_ctrl, okvl_dpath
//
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+---------------------
// request  | in_kind, in_key, in_value, in_position        | start & !busy
// result   | out_ok, out_found_key, out_found_value,       | out_valid, 1 cycle
//          | out_is_empty                                  |
//
// append, remove last, clear, unknown kinds and a position out of range never
// raise busy; their result comes in the cycle after the accepting edge.
// search holds busy while it walks the entries up to a match or the list end,
// and remove at position while it moves each later entry down one place (none
// for the tail entry), using the single read port walked one entry a cycle.
// the result strobe follows the last busy cycle; the receiver cannot stall.
// reset empties the list; entry contents are not cleared.
module ordered_key_value_list #(
  parameter int CAPACITY = okvl_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [okvl_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [okvl_pkg::KEY_W-1:0] in_key,
  input  logic signed [okvl_pkg::VAL_W-1:0] in_value,
  input  logic [okvl_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [okvl_pkg::KEY_W-1:0] out_found_key,
  output logic signed [okvl_pkg::VAL_W-1:0] out_found_value,
  output logic                              out_is_empty
);

  okvl_pkg::cmd_t    cmd;
  okvl_pkg::status_t status;

  // sequencer
  okvl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // entry store and result registers
  okvl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_found_key   (out_found_key),
    .out_found_value (out_found_value),
    .out_is_empty    (out_is_empty)
  );

endmodule
